// File: rtl/s256_pkg.sv
package s256_pkg;

    localparam int WordW    = 32;
    localparam int BlkWords = 16;
    localparam int Rounds   = 64;
    localparam int CountW   = 61;

    localparam logic [7:0] PadByte = 8'h80;

    typedef logic [WordW-1:0] word_t;

    localparam word_t INIT_HASH [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

    localparam word_t ROUND_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

    localparam logic FuncAbsorb = 1'b0;
    localparam logic FuncFinish = 1'b1;

    // request from the control unit to the compression core
    typedef struct packed {
        logic start;
        logic load_init;
    } core_ctl_t;

    typedef struct packed {
        logic busy;
        logic done;
    } core_sts_t;

    function automatic word_t rotr(input word_t v, input int n);
        rotr = (v >> n) | (v << (WordW - n));
    endfunction

endpackage

// File: rtl/s256_ram.sv
module s256_ram #(
    parameter int Width = 8,
    parameter int Depth = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(Depth)-1:0] waddr,
    input  logic [Width-1:0]         wdata,
    input  logic [$clog2(Depth)-1:0] raddr,
    output logic [Width-1:0]         rdata
);

    logic [Width-1:0] mem [Depth];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: rtl/s256_core.sv
// compression core: message schedule in a 16-word window, one round per cycle,
// chaining value kept in an 8-entry ram read and written one word a cycle
module s256_core (
    input  logic                    clk,
    input  logic                    rst_n,
    input  s256_pkg::core_ctl_t     ctl,
    // block words, loaded in order before start
    input  logic                    w_load,
    input  s256_pkg::word_t         w_data,
    output s256_pkg::core_sts_t     sts,
    input  logic [2:0]              hv_raddr,
    output s256_pkg::word_t         hv_rdata
);

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_LOAD  = 5'b00010,
        S_ROUND = 5'b00100,
        S_ADD   = 5'b01000,
        S_INIT  = 5'b10000
    } cst_t;

    cst_t            state_reg, state_next;
    logic [6:0]      cnt_reg, cnt_next;
    s256_pkg::word_t win_reg [16];
    s256_pkg::word_t v_reg [8];
    s256_pkg::word_t v_next [8];
    s256_pkg::word_t new_w;
    s256_pkg::word_t w_cur;
    s256_pkg::word_t t1, t2, s0, s1, ch, mj;

    logic            hv_we;
    logic [2:0]      hv_waddr, hv_ra;
    s256_pkg::word_t hv_wdata, hv_q;

    s256_ram #(.Width(s256_pkg::WordW), .Depth(8)) u_hv (
        .clk(clk), .we(hv_we), .waddr(hv_waddr), .wdata(hv_wdata),
        .raddr(hv_ra), .rdata(hv_q)
    );

    assign hv_rdata = hv_q;

    always_comb
    begin
        s0 = s256_pkg::rotr(win_reg[1], 7) ^ s256_pkg::rotr(win_reg[1], 18)
           ^ (win_reg[1] >> 3);
        s1 = s256_pkg::rotr(win_reg[14], 17) ^ s256_pkg::rotr(win_reg[14], 19)
           ^ (win_reg[14] >> 10);
        new_w = win_reg[0] + s0 + win_reg[9] + s1;
        w_cur = win_reg[0];
        ch = (v_reg[4] & v_reg[5]) ^ (~v_reg[4] & v_reg[6]);
        mj = (v_reg[0] & v_reg[1]) ^ (v_reg[0] & v_reg[2]) ^ (v_reg[1] & v_reg[2]);
        t1 = v_reg[7] + (s256_pkg::rotr(v_reg[4], 6) ^ s256_pkg::rotr(v_reg[4], 11)
           ^ s256_pkg::rotr(v_reg[4], 25)) + ch + s256_pkg::ROUND_K[cnt_reg[5:0]] + w_cur;
        t2 = (s256_pkg::rotr(v_reg[0], 2) ^ s256_pkg::rotr(v_reg[0], 13)
           ^ s256_pkg::rotr(v_reg[0], 22)) + mj;
        v_next[0] = t1 + t2;
        v_next[1] = v_reg[0];
        v_next[2] = v_reg[1];
        v_next[3] = v_reg[2];
        v_next[4] = v_reg[3] + t1;
        v_next[5] = v_reg[4];
        v_next[6] = v_reg[5];
        v_next[7] = v_reg[6];
    end

    // load: read hv words 0..7 into v (cnt 0..8, the ram read is registered)
    // add: read hv words, write back sum
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        hv_we      = 1'b0;
        hv_waddr   = 3'd0;
        hv_wdata   = hv_q;
        hv_ra      = hv_raddr;
        sts.done   = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (ctl.load_init)
                begin
                    state_next = S_INIT;
                    cnt_next   = 7'd0;
                end
                else if (ctl.start)
                begin
                    state_next = S_LOAD;
                    cnt_next   = 7'd0;
                end
            end
            S_INIT:
            begin
                hv_we    = 1'b1;
                hv_waddr = cnt_reg[2:0];
                hv_wdata = s256_pkg::INIT_HASH[cnt_reg[2:0]];
                cnt_next = cnt_reg + 7'd1;
                if (cnt_reg == 7'd7)
                begin
                    state_next = S_IDLE;
                    sts.done   = 1'b1;
                end
            end
            S_LOAD:
            begin
                hv_ra    = cnt_reg[2:0];
                cnt_next = cnt_reg + 7'd1;
                if (cnt_reg == 7'd8)
                begin
                    state_next = S_ROUND;
                    cnt_next   = 7'd0;
                end
            end
            S_ROUND:
            begin
                cnt_next = cnt_reg + 7'd1;
                if (cnt_reg == 7'd63)
                begin
                    state_next = S_ADD;
                    cnt_next   = 7'd0;
                end
            end
            S_ADD:
            begin
                hv_ra    = cnt_reg[2:0];
                hv_we    = (cnt_reg != 7'd0);
                hv_waddr = 3'(cnt_reg - 7'd1);
                hv_wdata = hv_q + v_reg[0];
                cnt_next = cnt_reg + 7'd1;
                if (cnt_reg == 7'd8)
                begin
                    state_next = S_IDLE;
                    sts.done   = 1'b1;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
        sts.busy = (state_reg != S_IDLE);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_INIT;
            cnt_reg   <= 7'd0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (w_load)
        begin
            for (int i = 0; i < 15; i++)
            begin
                win_reg[i] <= win_reg[i+1];
            end
            win_reg[15] <= w_data;
        end
        else if (state_reg == S_ROUND)
        begin
            for (int i = 0; i < 15; i++)
            begin
                win_reg[i] <= win_reg[i+1];
            end
            win_reg[15] <= new_w;
        end
        case (state_reg)
            S_LOAD:
            begin
                // shift words in at v[7] so v[0] ends with hv0
                if (cnt_reg != 7'd0)
                begin
                    for (int i = 0; i < 7; i++)
                    begin
                        v_reg[i] <= v_reg[i+1];
                    end
                    v_reg[7] <= hv_q;
                end
            end
            S_ROUND:
            begin
                for (int i = 0; i < 8; i++)
                begin
                    v_reg[i] <= v_next[i];
                end
            end
            S_ADD:
            begin
                if (cnt_reg != 7'd0)
                begin
                    for (int i = 0; i < 7; i++)
                    begin
                        v_reg[i] <= v_reg[i+1];
                    end
                    v_reg[7] <= v_reg[0];
                end
            end
            default:
            begin
            end
        endcase
    end

endmodule

// File: rtl/sha256_stream_hasher.sv
// channel | dir | handshake          | payload
// s_axis  | in  | tvalid/tready      | tdata[7:0] data_byte, tuser func
// m_axis  | out | tvalid/tready      | tdata[31:0] digest_word, tlast last_word
//
// absorb only writes the byte ram; the 64th byte of a block holds off input while
// the block is fetched from the byte ram, the core is started, loads the hash ram,
// runs 64 rounds and writes back the sum. finish runs one or two padded blocks the
// same way, emits eight words, each read from the hash ram and then offered, then
// rewrites the initial hash ram, and after reset that rewrite runs before any request.
// output stalls hold the word steady; the last word may still wait at the next request.
module sha256_stream_hasher (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // data_byte
    input  logic        s_axis_tuser,   // func
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // digest_word
    output logic        m_axis_tlast    // last_word
);

    typedef enum logic [6:0] {
        T_IDLE  = 7'b0000001,
        T_PAD   = 7'b0000010,
        T_FEED  = 7'b0000100,
        T_COMP  = 7'b0001000,
        T_EMIT  = 7'b0010000,
        T_OUT   = 7'b0100000,
        T_INIT  = 7'b1000000
    } tst_t;

    tst_t        state_reg, state_next;
    logic [5:0]  fill_reg, fill_next;
    logic [60:0] count_reg, count_next;
    logic        fin_reg, fin_next;       // finishing message
    logic        two_reg, two_next;       // second padded block pending
    logic        second_reg, second_next; // working on second block
    logic [6:0]  idx_reg, idx_next;       // byte index during feed/pad
    logic [2:0]  wi_reg, wi_next;         // output word index
    logic [31:0] acc_reg, acc_next;
    logic        ovalid_reg, ovalid_next;
    logic [31:0] odata_reg, odata_next;
    logic        olast_reg, olast_next;

    logic        ram_we;
    logic [5:0]  ram_wa, ram_ra;
    logic [7:0]  ram_wd, ram_q;
    logic        rd_v_reg;
    logic [5:0]  rd_i_reg;

    s256_pkg::core_ctl_t ctl;
    s256_pkg::core_sts_t sts;
    logic        w_load;
    logic [7:0]  fbyte;
    logic [63:0] bits;
    logic [2:0]  hv_ra;
    s256_pkg::word_t hv_q;
    logic        acc;

    s256_ram #(.Width(8), .Depth(64)) u_buf (
        .clk(clk), .we(ram_we), .waddr(ram_wa), .wdata(ram_wd),
        .raddr(ram_ra), .rdata(ram_q)
    );

    s256_core u_core (
        .clk(clk), .rst_n(rst_n), .ctl(ctl), .w_load(w_load), .w_data(acc_next),
        .sts(sts), .hv_raddr(hv_ra), .hv_rdata(hv_q)
    );

    assign acc  = s_axis_tvalid && s_axis_tready;
    assign bits = {count_reg, 3'b000};

    // byte of the current (possibly padded) block at the read index
    always_comb
    begin
        logic [6:0] p;
        p = {second_reg, rd_i_reg};
        if (!fin_reg || p < {1'b0, fill_reg})
        begin
            fbyte = ram_q;
        end
        else if (p == {1'b0, fill_reg})
        begin
            fbyte = s256_pkg::PadByte;
        end
        else if ((two_reg || second_reg) ? (p >= 7'd120) : (p >= 7'd56 && p < 7'd64))
        begin
            fbyte = bits[8*(7 - p[2:0]) +: 8];
        end
        else
        begin
            fbyte = 8'h00;
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        fill_next    = fill_reg;
        count_next   = count_reg;
        fin_next     = fin_reg;
        two_next     = two_reg;
        second_next  = second_reg;
        idx_next     = idx_reg;
        wi_next      = wi_reg;
        acc_next     = acc_reg;
        ovalid_next  = ovalid_reg;
        odata_next   = odata_reg;
        olast_next   = olast_reg;
        ram_we       = 1'b0;
        ram_wa       = fill_reg;
        ram_wd       = s_axis_tdata;
        ram_ra       = idx_reg[5:0];
        ctl          = '0;
        w_load       = 1'b0;
        hv_ra        = wi_reg;
        s_axis_tready = 1'b0;

        if (ovalid_reg && m_axis_tready)
        begin
            ovalid_next = 1'b0;
        end
        if (rd_v_reg)
        begin
            acc_next = {acc_reg[23:0], fbyte};
            w_load   = (rd_i_reg[1:0] == 2'd3);
        end

        case (state_reg)
            T_IDLE:
            begin
                s_axis_tready = 1'b1;
                if (acc)
                begin
                    if (s_axis_tuser == s256_pkg::FuncAbsorb)
                    begin
                        ram_we     = 1'b1;
                        fill_next  = fill_reg + 6'd1;
                        count_next = count_reg + 61'd1;
                        if (fill_reg == 6'd63)
                        begin
                            state_next = T_FEED;
                            idx_next   = 7'd0;
                        end
                    end
                    else
                    begin
                        fin_next    = 1'b1;
                        two_next    = (fill_reg > 6'd55);
                        second_next = 1'b0;
                        state_next  = T_FEED;
                        idx_next    = 7'd0;
                    end
                end
            end
            T_FEED:
            begin
                // read 64 bytes, one a cycle, packed into words for the core
                idx_next = idx_reg + 7'd1;
                if (idx_reg == 7'd63)
                begin
                    state_next = T_PAD;
                end
            end
            T_PAD:
            begin
                // last byte lands this cycle, then start
                state_next = T_COMP;
                ctl.start  = 1'b1;
            end
            T_COMP:
            begin
                if (sts.done)
                begin
                    if (!fin_reg)
                    begin
                        state_next = T_IDLE;
                    end
                    else if (two_reg && !second_reg)
                    begin
                        second_next = 1'b1;
                        state_next  = T_FEED;
                        idx_next    = 7'd0;
                    end
                    else
                    begin
                        state_next = T_EMIT;
                        wi_next    = 3'd0;
                    end
                end
            end
            T_EMIT:
            begin
                // hv ram read address already set to wi; data next cycle
                state_next = T_OUT;
            end
            T_OUT:
            begin
                if (!ovalid_reg || m_axis_tready)
                begin
                    ovalid_next = 1'b1;
                    odata_next  = hv_q;
                    olast_next  = (wi_reg == 3'd7);
                    wi_next     = wi_reg + 3'd1;
                    if (wi_reg == 3'd7)
                    begin
                        state_next = T_INIT;
                        ctl.load_init = 1'b1;
                    end
                    else
                    begin
                        state_next = T_EMIT;
                        hv_ra      = wi_reg + 3'd1;
                    end
                end
            end
            T_INIT:
            begin
                fill_next  = 6'd0;
                count_next = 61'd0;
                fin_next   = 1'b0;
                two_next   = 1'b0;
                second_next = 1'b0;
                if (sts.done)
                begin
                    state_next = T_IDLE;
                end
            end
            default:
            begin
                state_next = T_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= T_INIT;
            fill_reg   <= 6'd0;
            count_reg  <= 61'd0;
            fin_reg    <= 1'b0;
            two_reg    <= 1'b0;
            second_reg <= 1'b0;
            idx_reg    <= 7'd0;
            wi_reg     <= 3'd0;
            ovalid_reg <= 1'b0;
            rd_v_reg   <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            fill_reg   <= fill_next;
            count_reg  <= count_next;
            fin_reg    <= fin_next;
            two_reg    <= two_next;
            second_reg <= second_next;
            idx_reg    <= idx_next;
            wi_reg     <= wi_next;
            ovalid_reg <= ovalid_next;
            rd_v_reg   <= (state_reg == T_FEED);
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg   <= acc_next;
        odata_reg <= odata_next;
        olast_reg <= olast_next;
        rd_i_reg  <= idx_reg[5:0];
    end

    assign m_axis_tvalid = ovalid_reg;
    assign m_axis_tdata  = odata_reg;
    assign m_axis_tlast  = olast_reg;

endmodule

// File: rtl/sha256_stream_hasher_chk.sv
module sha256_stream_hasher_chk (
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        s_axis_tuser,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [31:0] m_axis_tdata,
    input logic        m_axis_tlast
);

    // a pending digest word holds until taken
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
        && $stable(m_axis_tlast))
        else $error("output word changed while stalled");

    // no request taken while digest words before the last are waiting
    a_no_in_out: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tlast |-> !s_axis_tready)
        else $error("input ready during digest output");

    // a finish request is not followed by input acceptance next cycle
    a_fin_busy: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready && s_axis_tuser |=> !s_axis_tready)
        else $error("ready right after finish");

    // after the last word goes out, nothing is valid next cycle
    a_last_gap: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tready && m_axis_tlast |=> !m_axis_tvalid)
        else $error("extra word after last");

endmodule

bind sha256_stream_hasher sha256_stream_hasher_chk u_chk (
    .clk(clk), .rst_n(rst_n), .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready), .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast)
);

// File: sim/sha256_stream_hasher_test.sv
module sha256_stream_hasher_test;

    timeunit 1ns;
    timeprecision 1ps;

    class digest_board;
        s256_pkg::word_t hash_state [8];
        logic [60:0]     msg_bytes;
        logic [7:0]      blk_bytes [64];
        int unsigned     blk_fill;
        s256_pkg::word_t pending_words [$];
        logic            pending_last [$];
        int              errors;

        function void clear_message();
            for (int i = 0; i < 8; i++)
            begin
                hash_state[i] = s256_pkg::INIT_HASH[i];
            end
            msg_bytes = '0;
            blk_fill  = 0;
        endfunction

        function void compress(input logic [7:0] blk [64]);
            s256_pkg::word_t sched [64];
            s256_pkg::word_t v [8];
            s256_pkg::word_t s0, s1, t1, t2, e, a;
            for (int i = 0; i < 16; i++)
            begin
                sched[i] = {blk[4*i], blk[4*i+1], blk[4*i+2], blk[4*i+3]};
            end
            for (int i = 16; i < 64; i++)
            begin
                s0 = {sched[i-15][6:0], sched[i-15][31:7]}
                   ^ {sched[i-15][17:0], sched[i-15][31:18]} ^ (sched[i-15] >> 3);
                s1 = {sched[i-2][16:0], sched[i-2][31:17]}
                   ^ {sched[i-2][18:0], sched[i-2][31:19]} ^ (sched[i-2] >> 10);
                sched[i] = sched[i-16] + s0 + sched[i-7] + s1;
            end
            v = hash_state;
            for (int i = 0; i < 64; i++)
            begin
                e  = v[4];
                a  = v[0];
                t1 = v[7] + ({e[5:0], e[31:6]} ^ {e[10:0], e[31:11]} ^ {e[24:0], e[31:25]})
                   + ((e & v[5]) ^ (~e & v[6])) + s256_pkg::ROUND_K[i] + sched[i];
                t2 = ({a[1:0], a[31:2]} ^ {a[12:0], a[31:13]} ^ {a[21:0], a[31:22]})
                   + ((a & v[1]) ^ (a & v[2]) ^ (v[1] & v[2]));
                v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
                v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
            end
            for (int i = 0; i < 8; i++)
            begin
                hash_state[i] += v[i];
            end
        endfunction

        function void note_request(input logic func, input logic [7:0] data);
            logic [7:0]  pad [128];
            logic [7:0]  half [64];
            logic [63:0] bit_len;
            int unsigned pos, total;
            if (func == s256_pkg::FuncAbsorb)
            begin
                blk_bytes[blk_fill] = data;
                blk_fill  = (blk_fill + 1) % 64;
                msg_bytes = msg_bytes + 1'b1;
                if (blk_fill == 0)
                begin
                    compress(blk_bytes);
                end
                return;
            end
            for (int i = 0; i < 128; i++)
            begin
                pad[i] = (i < blk_fill) ? blk_bytes[i] : 8'h00;
            end
            pos = blk_fill;
            pad[pos] = s256_pkg::PadByte;
            pos++;
            total = (pos <= 56) ? 64 : 128;
            bit_len = {msg_bytes, 3'b000};
            for (int k = 0; k < 8; k++)
            begin
                pad[total-1-k] = bit_len[8*k +: 8];
            end
            for (int b = 0; b < total / 64; b++)
            begin
                for (int i = 0; i < 64; i++)
                begin
                    half[i] = pad[64*b + i];
                end
                compress(half);
            end
            for (int k = 0; k < 8; k++)
            begin
                pending_words.push_back(hash_state[k]);
                pending_last.push_back(k == 7);
            end
            clear_message();
        endfunction

        function void check_word(input s256_pkg::word_t word, input logic last);
            s256_pkg::word_t exp_word;
            logic            exp_last;
            if (pending_words.size() == 0)
            begin
                $display("%0t: unexpected digest word %h last %b", $time, word, last);
                errors++;
                return;
            end
            exp_word = pending_words.pop_front();
            exp_last = pending_last.pop_front();
            if (word !== exp_word)
            begin
                $display("%0t: digest word expected %h actual %h", $time, exp_word, word);
                errors++;
            end
            if (last !== exp_last)
            begin
                $display("%0t: last flag expected %b actual %b", $time, exp_last, last);
                errors++;
            end
        endfunction
    endclass

    localparam int CycleLimit = 400000;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;   // data_byte
    logic        s_axis_tuser;   // func
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [31:0] m_axis_tdata;   // digest_word
    logic        m_axis_tlast;   // last_word

    digest_board board;
    int          cycle_count;
    int          burst_left;
    bit          long_hold;
    bit          stall_mode;

    sha256_stream_hasher uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #2 clk = ~clk;
        end
    end

    initial
    begin
        cycle_count = 0;
        forever
        begin
            @(posedge clk);
            cycle_count++;
            if (cycle_count > CycleLimit)
            begin
                $display("end of test: mismatches");
                $finish;
            end
        end
    end

    // receiver: random stalls alternating with stall-free stretches, full stall while long_hold is set
    initial
    begin
        m_axis_tready = 1'b0;
        stall_mode    = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (m_axis_tvalid && m_axis_tready)
            begin
                board.check_word(m_axis_tdata, m_axis_tlast);
            end
            if (long_hold)
            begin
                m_axis_tready <= 1'b0;
            end
            else
            begin
                if ($urandom_range(0, 99) == 0)
                begin
                    stall_mode = ~stall_mode;
                end
                m_axis_tready <= stall_mode ? ($urandom_range(0, 3) != 0) : 1'b1;
            end
        end
    end

    // one request, with burst and gap shaping on the sender side
    task automatic send_request(input logic func, input logic [7:0] data);
        if (burst_left == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
            burst_left = $urandom_range(1, 40);
        end
        burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= func;
        s_axis_tdata  <= data;
        do
        begin
            @(posedge clk);
        end
        while (!s_axis_tready);
        board.note_request(func, data);
    endtask

    task automatic send_message(input int unsigned len, input int fixed_byte);
        for (int i = 0; i < len; i++)
        begin
            send_request(s256_pkg::FuncAbsorb,
                         fixed_byte < 0 ? 8'($urandom) : 8'(fixed_byte));
        end
        send_request(s256_pkg::FuncFinish, 8'($urandom));
    endtask

    task automatic drain_all();
        s_axis_tvalid <= 1'b0;
        while (board.pending_words.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    initial
    begin
        board = new();
        board.clear_message();
        board.errors = 0;
        burst_left = 0;
        long_hold  = 1'b0;
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = 8'h00;
        s_axis_tuser  = s256_pkg::FuncAbsorb;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty message, single bytes at the extremes, a short message
        send_message(0, 0);
        send_message(1, 8'h00);
        send_message(1, 8'hff);
        send_message(3, -1);
        drain_all();

        // receiver holds off while the sender keeps offering requests
        long_hold = 1'b1;
        fork
        begin
            repeat (3000) @(posedge clk);
            long_hold = 1'b0;
        end
        begin
            for (int m = 0; m < 4; m++)
            begin
                send_message(0, 0);
            end
        end
        join
        drain_all();

        // two-block padding, and a full block followed by an empty tail
        send_message(56, -1);
        send_message(64, -1);
        drain_all();

        // random short messages
        for (int m = 0; m < 4; m++)
        begin
            send_message($urandom_range(0, 12), -1);
        end
        drain_all();
        repeat (200) @(posedge clk);

        if (board.errors == 0 && board.pending_words.size() == 0)
        begin
            $display("end of test: clean");
        end
        else
        begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

// File: files.f
rtl/s256_pkg.sv
rtl/s256_ram.sv
rtl/s256_core.sv
rtl/sha256_stream_hasher.sv
rtl/sha256_stream_hasher_chk.sv
sim/sha256_stream_hasher_test.sv
